// ===== hdl/touch_event_edge_zone_router_unit_assert.svh =====
// Assertion macros shared by the checker of the touch event edge zone router.
`ifndef TOUCH_EVENT_EDGE_ZONE_ROUTER_UNIT_ASSERT_SVH
`define TOUCH_EVENT_EDGE_ZONE_ROUTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define TEZR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define TEZR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tezr_pkg.sv =====
// Types, codes and constants shared by the touch event edge zone router.
`timescale 1ns / 1ps

package tezr_pkg;

    localparam int SLOT_COUNT_DEF = 10;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    localparam logic [1:0] CFG_RIM_ENABLE   = 2'd0;
    localparam logic [1:0] CFG_SCREEN_WIDTH = 2'd1;
    localparam logic [1:0] CFG_RIM_WIDTH    = 2'd2;
    localparam logic [1:0] CFG_GUARD_WIDTH  = 2'd3;

    localparam logic [11:0] SCREEN_WIDTH_RST = 12'd1080;
    localparam logic [10:0] RIM_WIDTH_RST    = 11'd36;
    localparam logic [10:0] GUARD_WIDTH_RST  = 11'd70;

    localparam int BIT_PRESS  = 7;
    localparam int BIT_SCREEN = 6;
    localparam int BIT_PALM   = 4;

    localparam logic [3:0] KEY_NUM_MAX   = 4'd3;
    localparam logic [9:0] PALM_PRESSURE = 10'd1000;

    localparam logic [1:0] KIND_TOUCH   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_KEY     = 2'd2;

    localparam logic TARGET_MAIN = 1'b0;
    localparam logic TARGET_RIM  = 1'b1;

    typedef enum logic [1:0] {
        ZONE_NEW    = 2'd0,
        ZONE_CENTER = 2'd1,
        ZONE_RIM    = 2'd2,
        ZONE_GUARD  = 2'd3
    } zone_t;

    typedef struct packed {
        logic        rim_enable;
        logic [11:0] screen_width;
        logic [10:0] rim_width;
        logic [10:0] guard_width;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        target;
        logic [3:0]  slot;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [7:0]  touch_size;
        logic [9:0]  touch_pressure;
        logic [1:0]  key_id;
        logic        key_pressed;
        logic        last;
    } result_t;

    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } pair_t;

endpackage

// ===== hdl/tezr_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module tezr_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 10,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/tezr_cfg.sv =====
// Configuration register file of the touch event edge zone router.
`timescale 1ns / 1ps

module tezr_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tezr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tezr_pkg::CFG_DATA_W-1:0]     cfg_data,
    output tezr_pkg::cfg_t                      cfg
);

    import tezr_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rim_enable   <= 1'b0;
            cfg_reg.screen_width <= SCREEN_WIDTH_RST;
            cfg_reg.rim_width    <= RIM_WIDTH_RST;
            cfg_reg.guard_width  <= GUARD_WIDTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RIM_ENABLE:   cfg_reg.rim_enable   <= cfg_data[0];
                CFG_SCREEN_WIDTH: cfg_reg.screen_width <= cfg_data[11:0];
                CFG_RIM_WIDTH:    cfg_reg.rim_width    <= cfg_data[10:0];
                CFG_GUARD_WIDTH:  cfg_reg.guard_width  <= cfg_data[10:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/tezr_zone_ctrl.sv =====
// Record decode, slot zone memory read-modify-write and result pair building.
`timescale 1ns / 1ps

module tezr_zone_ctrl #(
    parameter int SLOT_COUNT = tezr_pkg::SLOT_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tezr_pkg::cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        status_byte,
    input  logic [7:0]        high_nibbles,
    input  logic [7:0]        x_low,
    input  logic [7:0]        y_low,
    input  logic [7:0]        major_byte,
    input  logic [7:0]        pressure_byte,
    output logic              pair_valid,
    input  logic              pair_ready,
    output tezr_pkg::pair_t   pair
);

    import tezr_pkg::*;

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    function automatic logic in_band(input logic [11:0] x, input logic [11:0] sw,
                                     input logic [10:0] band);
        logic signed [13:0] hi;
        hi = $signed({2'b00, sw}) - $signed({3'b000, band});
        return (x < {1'b0, band}) || ($signed({2'b00, x}) > hi);
    endfunction

    logic [3:0]  nib;
    logic [3:0]  slot_num;
    logic        is_screen;
    logic        key_ok;
    logic        slot_ok;
    logic        accept;
    logic        b_stall;
    logic        b_fire;

    logic        b_valid_reg;
    logic        b_key_reg;
    logic [3:0]  b_slot_reg;
    logic [11:0] b_x_reg;
    logic [11:0] b_y_reg;
    logic [7:0]  b_size_reg;
    logic [7:0]  b_pres_reg;
    logic        b_press_reg;
    logic        b_palm_reg;

    logic [SLOT_COUNT-1:0] zone_valid_reg;
    logic                  fwd_en_reg;
    logic [AW-1:0]         fwd_addr_reg;
    zone_t                 fwd_zone_reg;

    logic [AW-1:0] b_addr;
    logic [AW-1:0] ram_raddr;
    logic [1:0]    ram_rdata;
    logic          we;

    zone_t   zone_cur;
    zone_t   zone_next;
    logic    rim_hit;
    logic    guard_hit;
    logic    pre_rel;
    logic    pre_tgt;
    logic    tgt;
    result_t main_res;
    result_t rel_res;

    assign nib       = status_byte[3:0];
    assign slot_num  = nib - 4'd1;
    assign is_screen = status_byte[BIT_SCREEN];
    assign key_ok    = !is_screen && (nib != 4'd0) && (nib <= KEY_NUM_MAX);
    assign slot_ok   = is_screen && (nib != 4'd0) && ({1'b0, slot_num} < 5'(SLOT_COUNT));

    assign b_stall    = b_valid_reg && !pair_ready;
    assign b_fire     = b_valid_reg && pair_ready;
    assign in_ready   = !b_stall;
    assign accept     = in_valid && in_ready;
    assign pair_valid = b_valid_reg;

    assign b_addr    = b_slot_reg[AW-1:0];
    assign ram_raddr = b_stall ? b_addr : slot_num[AW-1:0];
    assign we        = b_fire && !b_key_reg;

    tezr_ram #(
        .WIDTH(2),
        .DEPTH(SLOT_COUNT)
    ) u_zone_ram (
        .clk   (clk),
        .we    (we),
        .waddr (b_addr),
        .wdata (2'(zone_next)),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (fwd_en_reg && (fwd_addr_reg == b_addr))
        begin
            zone_cur = fwd_zone_reg;
        end
        else if (zone_valid_reg[b_addr])
        begin
            zone_cur = zone_t'(ram_rdata);
        end
        else
        begin
            zone_cur = ZONE_NEW;
        end

        rim_hit   = in_band(b_x_reg, cfg.screen_width, cfg.rim_width);
        guard_hit = !rim_hit && in_band(b_x_reg, cfg.screen_width, cfg.guard_width);

        zone_next = zone_cur;
        pre_rel   = 1'b0;
        pre_tgt   = TARGET_MAIN;
        tgt       = TARGET_MAIN;

        if (cfg.rim_enable && !b_key_reg)
        begin
            unique case (zone_cur)
                ZONE_RIM:
                begin
                    if (rim_hit)
                    begin
                        tgt = TARGET_RIM;
                    end
                    else
                    begin
                        pre_rel   = 1'b1;
                        pre_tgt   = TARGET_RIM;
                        zone_next = guard_hit ? ZONE_GUARD : ZONE_CENTER;
                    end
                end
                ZONE_CENTER:
                begin
                    tgt = TARGET_MAIN;
                end
                ZONE_GUARD:
                begin
                    if (rim_hit)
                    begin
                        pre_rel   = 1'b1;
                        pre_tgt   = TARGET_MAIN;
                        zone_next = ZONE_RIM;
                        tgt       = TARGET_RIM;
                    end
                    else if (!guard_hit)
                    begin
                        zone_next = ZONE_CENTER;
                    end
                end
                ZONE_NEW:
                begin
                    zone_next = rim_hit ? ZONE_RIM : (guard_hit ? ZONE_GUARD : ZONE_CENTER);
                    tgt       = rim_hit ? TARGET_RIM : TARGET_MAIN;
                end
            endcase
        end

        main_res      = '0;
        main_res.last = 1'b1;
        if (b_key_reg)
        begin
            main_res.kind        = KIND_KEY;
            main_res.key_id      = b_slot_reg[1:0];
            main_res.key_pressed = b_press_reg;
        end
        else if (b_press_reg)
        begin
            main_res.kind           = KIND_TOUCH;
            main_res.target         = tgt;
            main_res.slot           = b_slot_reg;
            main_res.pos_x          = b_x_reg;
            main_res.pos_y          = b_y_reg;
            main_res.touch_size     = b_size_reg;
            main_res.touch_pressure = b_palm_reg ? PALM_PRESSURE : {2'b00, b_pres_reg};
        end
        else
        begin
            main_res.kind   = KIND_RELEASE;
            main_res.target = tgt;
            main_res.slot   = b_slot_reg;
            zone_next       = ZONE_NEW;
        end

        rel_res        = '0;
        rel_res.kind   = KIND_RELEASE;
        rel_res.target = pre_tgt;
        rel_res.slot   = b_slot_reg;

        pair.two    = pre_rel;
        pair.first  = pre_rel ? rel_res : main_res;
        pair.second = main_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg    <= 1'b0;
            fwd_en_reg     <= 1'b0;
            zone_valid_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                b_valid_reg <= accept && (key_ok || slot_ok);
            end
            fwd_en_reg <= we;
            if (we)
            begin
                zone_valid_reg[b_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_key_reg   <= !is_screen;
            b_slot_reg  <= slot_num;
            b_x_reg     <= {high_nibbles[3:0], x_low};
            b_y_reg     <= {high_nibbles[7:4], y_low};
            b_size_reg  <= major_byte;
            b_pres_reg  <= pressure_byte;
            b_press_reg <= status_byte[BIT_PRESS];
            b_palm_reg  <= status_byte[BIT_PALM];
        end
        if (we)
        begin
            fwd_addr_reg <= b_addr;
            fwd_zone_reg <= zone_next;
        end
    end

endmodule

// ===== hdl/tezr_out_buf.sv =====
// Two-entry output holding register that drains a result pair one item at a time.
`timescale 1ns / 1ps

module tezr_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pair_valid,
    output logic               pair_ready,
    input  tezr_pkg::pair_t    pair,
    output logic               out_valid,
    input  logic               out_ready,
    output tezr_pkg::result_t  res
);

    import tezr_pkg::*;

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    result_t    res0_reg;
    result_t    res1_reg;
    logic       load;
    logic       take;

    assign out_valid  = (cnt_reg != 2'd0);
    assign pair_ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);
    assign load       = pair_valid && pair_ready;
    assign take       = out_valid && out_ready;
    assign res        = res0_reg;

    always_comb
    begin
        if (load)
        begin
            cnt_next = pair.two ? 2'd2 : 2'd1;
        end
        else if (take)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res0_reg <= pair.first;
            res1_reg <= pair.second;
        end
        else if (take && (cnt_reg == 2'd2))
        begin
            res0_reg <= res1_reg;
        end
    end

endmodule

// ===== hdl/touch_event_edge_zone_router_unit.sv =====
// Top level of the touch event edge zone router.
`timescale 1ns / 1ps

// The input channel (in_valid/in_ready) takes one six-byte touch record per item.
// The output channel (out_valid/out_ready) gives one report per item; a record
// yields zero, one or two reports, and the final one of a record has last set.
// Key records and bad slot ids are checked on entry; dropped records give nothing.
// A record accepted is registered in the decode stage and its report then in the
// output register, where it can be taken. Each record reads its slot zone from a
// small synchronous memory as it is accepted and writes it back as it leaves the
// decode stage, with forwarding between back-to-back records on the same slot.
// Throughput is one record per cycle while out_ready stays high and each record
// yields one report; a zone change holds the next record until the two-entry output
// register has drained its first report, one report per cycle while out_ready is high.
// The configuration port writes a register at any edge with cfg_we high; the user
// must use it only while the block is idle, which the block does not enforce.
// Reset restores the register defaults and marks every slot as new at once.
// When the receiver stalls, the output register holds its report, the stage
// behind it holds its record and re-reads its zone, and in_ready falls.
module touch_event_edge_zone_router_unit #(
    parameter int SLOT_COUNT = tezr_pkg::SLOT_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tezr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tezr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          status_byte,
    input  logic [7:0]                          high_nibbles,
    input  logic [7:0]                          x_low,
    input  logic [7:0]                          y_low,
    input  logic [7:0]                          major_byte,
    input  logic [7:0]                          pressure_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          kind,
    output logic                                target,
    output logic [3:0]                          slot,
    output logic [11:0]                         pos_x,
    output logic [11:0]                         pos_y,
    output logic [7:0]                          touch_size,
    output logic [9:0]                          touch_pressure,
    output logic [1:0]                          key_id,
    output logic                                key_pressed,
    output logic                                last
);

    import tezr_pkg::*;

    cfg_t    cfg;
    pair_t   pair;
    logic    pair_valid;
    logic    pair_ready;
    result_t res;

    tezr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tezr_zone_ctrl #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_zone_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .status_byte   (status_byte),
        .high_nibbles  (high_nibbles),
        .x_low         (x_low),
        .y_low         (y_low),
        .major_byte    (major_byte),
        .pressure_byte (pressure_byte),
        .pair_valid    (pair_valid),
        .pair_ready    (pair_ready),
        .pair          (pair)
    );

    tezr_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .pair_ready (pair_ready),
        .pair       (pair),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .res        (res)
    );

    assign kind           = res.kind;
    assign target         = res.target;
    assign slot           = res.slot;
    assign pos_x          = res.pos_x;
    assign pos_y          = res.pos_y;
    assign touch_size     = res.touch_size;
    assign touch_pressure = res.touch_pressure;
    assign key_id         = res.key_id;
    assign key_pressed    = res.key_pressed;
    assign last           = res.last;

endmodule

// ===== hdl/tezr_assert_chk.sv =====
// Port-level assertion checker for the touch event edge zone router and its bind.
`timescale 1ns / 1ps
`include "touch_event_edge_zone_router_unit_assert.svh"

module tezr_assert_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic        target,
    input logic [3:0]  slot,
    input logic [11:0] pos_x,
    input logic [9:0]  touch_pressure,
    input logic        last
);

    import tezr_pkg::*;

    `TEZR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(slot), "report changed while stalled")

    `TEZR_ASSERT_IMP(a_key_shape, out_valid && (kind == KIND_KEY), last && (slot == 4'd0) && (target == TARGET_MAIN) && (pos_x == 12'd0), "malformed key report")

    `TEZR_ASSERT_IMP(a_pressure, out_valid && (kind == KIND_TOUCH), (touch_pressure < 10'd256) || (touch_pressure == PALM_PRESSURE), "touch pressure out of range")

    `TEZR_ASSERT_NEXT(a_pair_follow, out_valid && out_ready && !last, out_valid && last && (slot == $past(slot)) && (target != $past(target)), "zone change release not followed by its report")

endmodule

bind touch_event_edge_zone_router_unit tezr_assert_chk u_tezr_assert_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .target         (target),
    .slot           (slot),
    .pos_x          (pos_x),
    .touch_pressure (touch_pressure),
    .last           (last)
);
